// ===== rtl/core/sidasc_pkg.sv =====
// Package for the signed integer to decimal ASCII unit: types, codes and constants.
package sidasc_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CHAR_W              = 6;
  localparam int COUNT_W             = 4;
  localparam int OUT_TDATA_W         = 16;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic shift;
    logic count;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_shift;
    logic out_free;
    logic emit_last;
  } sts_t;

  // decimal digits needed for a w-bit magnitude (floor(w*log10(2)) + 1)
  function automatic int bcd_digits(input int w);
    return ((w * 1233) >>> 12) + 1;
  endfunction

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii_unit.sv =====
// Top level of the signed integer to decimal ASCII unit.
//
// One word on the in_ channel is a two's complement integer of VALUE_WIDTH
// bits. The unit answers with its decimal text on the out_ channel, one
// ASCII character per word, most significant first, a '-' ahead of
// negative values, out_tlast on the final character, which alone carries
// the character count (1 to 11 at 32 bits).
// An input is taken in the idle state; the magnitude then passes through a
// shift-add-3 BCD converter one bit per cycle, a count state finds the digit
// count, and then one character leaves per cycle unless out_tready stalls
// the output.
// in_tready is high only while no number is being converted or sent; the
// next number is taken while the last character still sits in the output
// register. A stalled out_tready holds the output word and pauses
// character generation. Reset (rst_n low, synchronous) returns the unit to
// idle and drops out_tvalid.
module signed_int_to_decimal_ascii_unit #(
  parameter  int VALUE_WIDTH = sidasc_pkg::DEFAULT_VALUE_WIDTH,
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_TDATA_W-1:0]             in_tdata,   // value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sidasc_pkg::OUT_TDATA_W-1:0] out_tdata, // character, char_count
  output logic                              out_tlast
);

  sidasc_pkg::cmd_t cmd;
  sidasc_pkg::sts_t sts;

  logic [sidasc_pkg::CHAR_W-1:0]  out_char;
  logic [sidasc_pkg::COUNT_W-1:0] out_count;

  sidasc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  sidasc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .value      (in_tdata[VALUE_WIDTH-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_char   (out_char),
    .out_last   (out_tlast),
    .out_count  (out_count)
  );

  assign in_tready = cmd.in_ready;
  assign out_tdata = {{(sidasc_pkg::OUT_TDATA_W - sidasc_pkg::CHAR_W - sidasc_pkg::COUNT_W){1'b0}},
                      out_count, out_char};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a conversion is running");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_char == sidasc_pkg::ASCII_MINUS) ||
                   (out_char >= sidasc_pkg::ASCII_ZERO &&
                    out_char <= sidasc_pkg::ASCII_ZERO + sidasc_pkg::CHAR_W'(9)))
    else $error("illegal output character");

  a_count_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_count == '0)
    else $error("character count on a non-final character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_char == sidasc_pkg::ASCII_MINUS |-> !out_tlast)
    else $error("minus sign sent as final character");

endmodule

// ===== rtl/core/sidasc_ctrl.sv =====
// Controller state machine of the signed integer to decimal ASCII unit.
module sidasc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  sidasc_pkg::sts_t  sts,
  output sidasc_pkg::cmd_t  cmd
);

  sidasc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sidasc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sidasc_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = sidasc_pkg::ST_CONV;
      end
      sidasc_pkg::ST_CONV: begin
        if (sts.last_shift) state_nxt = sidasc_pkg::ST_COUNT;
      end
      sidasc_pkg::ST_COUNT: begin
        state_nxt = sidasc_pkg::ST_EMIT;
      end
      sidasc_pkg::ST_EMIT: begin
        if (sts.out_free && sts.emit_last) state_nxt = sidasc_pkg::ST_IDLE;
      end
      default: state_nxt = sidasc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      sidasc_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_tvalid;
      end
      sidasc_pkg::ST_CONV:  cmd.shift = 1'b1;
      sidasc_pkg::ST_COUNT: cmd.count = 1'b1;
      sidasc_pkg::ST_EMIT:  cmd.emit  = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/sidasc_datapath.sv =====
// Datapath: magnitude, shift-add-3 BCD converter, digit count and output register.
module sidasc_datapath #(
  parameter int VALUE_WIDTH = sidasc_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [VALUE_WIDTH-1:0]           value,
  input  sidasc_pkg::cmd_t                 cmd,
  output sidasc_pkg::sts_t                 sts,
  input  logic                             out_tready,
  output logic                             out_valid,
  output logic [sidasc_pkg::CHAR_W-1:0]    out_char,
  output logic                             out_last,
  output logic [sidasc_pkg::COUNT_W-1:0]   out_count
);

  localparam int NDIG = sidasc_pkg::bcd_digits(VALUE_WIDTH);
  localparam int BW   = $clog2(VALUE_WIDTH);
  localparam int PW   = $clog2(NDIG + 1);
  localparam int IW   = $clog2(NDIG);
  localparam int TW   = (PW + 1 > sidasc_pkg::COUNT_W) ? PW + 1 : sidasc_pkg::COUNT_W;

  logic [VALUE_WIDTH-1:0] mag_r;
  logic [NDIG*4-1:0]      bcd_r;
  logic                   neg_r;
  logic [BW-1:0]          bitcnt_r;
  logic [PW-1:0]          ndig_r;
  logic [PW-1:0]          pos_r;
  logic                   sign_pend_r;

  logic                   out_valid_r;
  logic [sidasc_pkg::CHAR_W-1:0]  out_char_r;
  logic                   out_last_r;
  logic [sidasc_pkg::COUNT_W-1:0] out_count_r;

  logic [NDIG*4-1:0]      bcd_adj;
  logic [3:0]             dig [NDIG];
  logic [PW-1:0]          ndig_nxt;
  logic [PW-1:0]          pos_dec;
  logic [3:0]             sel_dig;
  logic [TW-1:0]          total;
  logic                   in_neg;

  assign in_neg = value[VALUE_WIDTH-1];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dig[i] = bcd_r[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
  end

  always_comb begin
    ndig_nxt = PW'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (dig[i] != 4'd0) ndig_nxt = PW'(i + 1);
    end
  end

  assign pos_dec = pos_r - PW'(1);
  assign sel_dig = dig[pos_dec[IW-1:0]];
  assign total   = TW'(ndig_r) + TW'(neg_r);

  assign sts.last_shift = (bitcnt_r == BW'(VALUE_WIDTH - 1));
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.emit_last  = !sign_pend_r && (pos_r == PW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r    <= in_neg ? (~value + VALUE_WIDTH'(1)) : value;
      neg_r    <= in_neg;
      bcd_r    <= '0;
      bitcnt_r <= '0;
    end else if (cmd.shift) begin
      bcd_r    <= {bcd_adj[NDIG*4-2:0], mag_r[VALUE_WIDTH-1]};
      mag_r    <= {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bitcnt_r <= bitcnt_r + BW'(1);
    end
    if (cmd.count) begin
      ndig_r <= ndig_nxt;
      pos_r  <= ndig_nxt;
    end else if (cmd.emit && !sign_pend_r) begin
      pos_r  <= pos_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.count) begin
        sign_pend_r <= neg_r;
      end else if (cmd.emit) begin
        sign_pend_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r  <= sign_pend_r ? sidasc_pkg::ASCII_MINUS
                                 : sidasc_pkg::ASCII_ZERO + sidasc_pkg::CHAR_W'(sel_dig);
      out_last_r  <= sts.emit_last;
      out_count_r <= sts.emit_last ? total[sidasc_pkg::COUNT_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_count = out_count_r;

endmodule
